// ===== rtl/crc_chk_pkg.sv =====
package crc_chk_pkg;

  // default sizes of the message and the generator
  localparam int DATA_BITS_DEF = 32;
  localparam int GEN_BITS_DEF  = 33;

  // received remainder is always 32 bits wide
  localparam int CHK_BITS = 32;

  // message bits consumed by one division stage
  localparam int BITS_PER_STAGE = 8;

  // widest remainder register and its shift amount
  localparam int CRC_W_MAX   = GEN_BITS_DEF - 1;
  localparam int SHAMT_W_MAX = $clog2(GEN_BITS_DEF);

  // result codes
  typedef enum logic [1:0] {
    ST_MISMATCH = 2'd0,
    ST_MATCH    = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  // values derived from the generator when it is written
  typedef struct packed {
    logic                   bad_gen;  // generator is zero
    logic [SHAMT_W_MAX-1:0] shamt;    // remainder width minus degree
    logic [CRC_W_MAX-1:0]   glow;     // generator below its top bit, left aligned
    logic [CHK_BITS-1:0]    hi_mask;  // remainder bits at or above the degree
  } cfg_t;

endpackage

// ===== rtl/crc_chk_top.sv =====
// CRC remainder check. Each item carries a message word and a received
// remainder; the block divides message * x^r + remainder by the configured
// generator over GF(2) and returns match, mismatch, or unreasonable input
// (zero generator, or a remainder wider than r bits). One item is taken every
// cycle unless the result side stalls. The pipeline has one entry register that
// aligns the remainder, one division stage per 8 message bits and one result
// register. A stall on the result side holds the whole pipeline. The generator
// is to be written by the user through its own port while no item is in flight;
// the block itself does not enforce this. A write takes effect at the next edge.
// After reset the generator is zero and every item reports unreasonable input.
module crc_remainder_check_top #(
  parameter int DATA_BITS = crc_chk_pkg::DATA_BITS_DEF,
  parameter int GEN_BITS  = crc_chk_pkg::GEN_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [GEN_BITS-1:0]                cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [DATA_BITS-1:0]               data_word_i,
  input  logic [crc_chk_pkg::CHK_BITS-1:0]   check_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         check_status_o
);

  localparam int W       = GEN_BITS - 1;
  localparam int STEPS   = crc_chk_pkg::BITS_PER_STAGE;
  localparam int NUM_DIV = (DATA_BITS + STEPS - 1) / STEPS;
  localparam int DP      = NUM_DIV * STEPS;

  crc_chk_pkg::cfg_t cfg;
  logic              en;

  logic [NUM_DIV:0] v;
  logic [NUM_DIV:0] bad;
  logic [DP-1:0]    data [NUM_DIV+1];
  logic [W-1:0]     crc  [NUM_DIV+1];
  logic [W-1:0]     chk  [NUM_DIV+1];

  logic [W-1:0] glow;
  logic [W-1:0] chk_al;
  logic         oversize;

  logic                 out_valid_q;
  crc_chk_pkg::status_e status_d, status_q;

  crc_chk_cfg #(
    .GEN_BITS(GEN_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the pipeline moves whenever the result register is free or drained
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // entry stage: align the remainder and flag unreasonable input
  assign glow     = cfg.glow[W-1:0];
  assign chk_al   = W'(check_bits_i[W-1:0] << cfg.shamt);
  assign oversize = |(check_bits_i & cfg.hi_mask);

  logic          v0_q, bad0_q;
  logic [DP-1:0] data0_q;
  logic [W-1:0]  chk0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad0_q  <= cfg.bad_gen || oversize;
      data0_q <= DP'(data_word_i);
      chk0_q  <= chk_al;
    end
  end

  assign v[0]    = v0_q;
  assign bad[0]  = bad0_q;
  assign data[0] = data0_q;
  assign crc[0]  = '0;
  assign chk[0]  = chk0_q;

  // division stages
  for (genvar s = 0; s < NUM_DIV; s++) begin : g_div
    crc_chk_div #(
      .W  (W),
      .DP (DP),
      .IDX(s)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v[s]),
      .bad_i  (bad[s]),
      .data_i (data[s]),
      .crc_i  (crc[s]),
      .chk_i  (chk[s]),
      .glow_i (glow),
      .valid_o(v[s+1]),
      .bad_o  (bad[s+1]),
      .data_o (data[s+1]),
      .crc_o  (crc[s+1]),
      .chk_o  (chk[s+1])
    );
  end

  // result stage: remainder is zero when the computed CRC equals the received one
  always_comb begin
    if (bad[NUM_DIV]) begin
      status_d = crc_chk_pkg::ST_BAD;
    end else if (crc[NUM_DIV] == chk[NUM_DIV]) begin
      status_d = crc_chk_pkg::ST_MATCH;
    end else begin
      status_d = crc_chk_pkg::ST_MISMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[NUM_DIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign check_status_o = status_q;

`ifndef SYNTH
  // an accepted item lands in the entry register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v0_q)
    else $error("accepted item missing from entry stage");

  // the last division stage feeds the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v[NUM_DIV] |=> out_valid_q)
    else $error("item lost before result stage");

  // a stall freezes every stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v) && $stable(out_valid_q))
    else $error("pipeline moved during stall");

  // an empty pipeline cannot produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && (v == '0) && !(in_valid_i && in_ready_o) |=> (v == '0))
    else $error("item appeared without acceptance");
`endif

endmodule

// ===== rtl/crc_chk_cfg.sv =====
module crc_chk_cfg #(
  parameter int GEN_BITS = crc_chk_pkg::GEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [GEN_BITS-1:0] cfg_data_i,
  output crc_chk_pkg::cfg_t   cfg_o
);

  localparam int W     = GEN_BITS - 1;
  localparam int DEG_W = $clog2(GEN_BITS);

  // reset value: zero generator
  localparam crc_chk_pkg::cfg_t CFG_RST = '{bad_gen: 1'b1, default: '0};

  logic [DEG_W-1:0]  deg;
  logic [DEG_W-1:0]  shamt;
  logic [W-1:0]      glow;
  crc_chk_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  // degree from the highest set bit
  always_comb begin
    deg = '0;
    for (int i = 0; i < GEN_BITS; i++) begin
      if (cfg_data_i[i]) begin
        deg = DEG_W'(i);
      end
    end
  end

  // left align the generator so the leading term drops off the top
  assign shamt = DEG_W'(W) - deg;
  assign glow  = W'(cfg_data_i[W-1:0] << shamt);

  always_comb begin
    cfg_d         = '0;
    cfg_d.bad_gen = (cfg_data_i == '0);
    cfg_d.shamt   = crc_chk_pkg::SHAMT_W_MAX'(shamt);
    cfg_d.glow    = crc_chk_pkg::CRC_W_MAX'(glow);
    for (int i = 0; i < crc_chk_pkg::CHK_BITS; i++) begin
      cfg_d.hi_mask[i] = (32'(i) >= 32'(deg));
    end
  end

  // after reset the generator is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/crc_chk_div.sv =====
module crc_chk_div #(
  parameter int W   = crc_chk_pkg::CRC_W_MAX,
  parameter int DP  = crc_chk_pkg::DATA_BITS_DEF,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          bad_i,
  input  logic [DP-1:0] data_i,
  input  logic [W-1:0]  crc_i,
  input  logic [W-1:0]  chk_i,
  input  logic [W-1:0]  glow_i,
  output logic          valid_o,
  output logic          bad_o,
  output logic [DP-1:0] data_o,
  output logic [W-1:0]  crc_o,
  output logic [W-1:0]  chk_o
);

  localparam int STEPS = crc_chk_pkg::BITS_PER_STAGE;
  localparam int TOP   = DP - 1 - STEPS * IDX;

  logic [W-1:0] crc_d, crc_q;
  logic         valid_q, bad_q;
  logic [DP-1:0] data_q;
  logic [W-1:0] chk_q;

  // one message bit per step, most significant first
  always_comb begin
    logic fb;
    crc_d = crc_i;
    for (int k = 0; k < STEPS; k++) begin
      fb    = data_i[TOP-k] ^ crc_d[W-1];
      crc_d = W'(crc_d << 1) ^ (fb ? glow_i : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q  <= bad_i;
      data_q <= data_i;
      crc_q  <= crc_d;
      chk_q  <= chk_i;
    end
  end

  assign valid_o = valid_q;
  assign bad_o   = bad_q;
  assign data_o  = data_q;
  assign crc_o   = crc_q;
  assign chk_o   = chk_q;

endmodule
